/* rtl/addressed_serial_frame_receiver_top_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the addressed serial frame receiver
// Concurrent checks that compile away when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef ADDRESSED_SERIAL_FRAME_RECEIVER_TOP_DEFINES_SVH
`define ADDRESSED_SERIAL_FRAME_RECEIVER_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/asfr_pkg.sv */
// ----------------------------------------------------------------------------
// Addressed serial frame receiver package
// Frame marker bytes and fixed positions within a frame.
// ----------------------------------------------------------------------------
package asfr_pkg;

    localparam logic [7:0] SYNC_A     = 8'hE7;
    localparam logic [7:0] SYNC_B     = 8'hD9;
    localparam logic [7:0] FRAME_TYPE = 8'h02;
    localparam logic [7:0] TAIL_A     = 8'hF8;
    localparam logic [7:0] TAIL_B     = 8'hC6;

    localparam logic [7:0] HDR_LEN    = 8'd14;

    localparam logic [7:0] POS_SYNC0  = 8'd1;
    localparam logic [7:0] POS_SYNC1  = 8'd2;
    localparam logic [7:0] POS_SYNC2  = 8'd3;
    localparam logic [7:0] POS_SYNC3  = 8'd4;
    localparam logic [7:0] POS_TYPE   = 8'd5;
    localparam logic [7:0] POS_ADDR   = 8'd6;
    localparam logic [7:0] POS_FREE   = 8'd7;
    localparam logic [7:0] POS_LEN    = 8'd8;

endpackage

/* rtl/asfr_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// Frame command queue
// Two-entry queue of completed frames (buffer bank and length) between
// the byte parser and the drain side.
// ----------------------------------------------------------------------------
module asfr_cmd_fifo #(
    parameter int MAX_FRAME = 50
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    input  logic                                 push_bank,
    input  logic [$clog2(MAX_FRAME + 1) - 1:0]   push_len,
    input  logic                                 pop,
    output logic                                 full,
    output logic                                 not_empty,
    output logic                                 head_bank,
    output logic [$clog2(MAX_FRAME + 1) - 1:0]   head_len
);

    localparam int LW = $clog2(MAX_FRAME + 1);

    logic          bank_reg [2];
    logic [LW-1:0] len_reg  [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    count_reg;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head_bank = bank_reg[rd_ptr_reg];
    assign head_len  = len_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            bank_reg[wr_ptr_reg] <= push_bank;
            len_reg[wr_ptr_reg]  <= push_len;
        end
    end

endmodule

/* rtl/asfr_parser.sv */
// ----------------------------------------------------------------------------
// Frame parser
// Checks each received byte against its frame position, writes kept bytes
// into the current buffer bank and queues the frame once the trailer ends.
// ----------------------------------------------------------------------------
module asfr_parser
    import asfr_pkg::*;
#(
    parameter int MAX_FRAME = 50
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [7:0]                           rx_byte,
    input  logic [7:0]                           station_id,
    input  logic                                 q_full,
    output logic                                 wr_en,
    output logic [$clog2(MAX_FRAME):0]           wr_addr,
    output logic [7:0]                           wr_data,
    output logic                                 push,
    output logic                                 push_bank,
    output logic [$clog2(MAX_FRAME + 1) - 1:0]   push_len
);

    localparam int PW = $clog2(MAX_FRAME + 2);
    localparam int AW = $clog2(MAX_FRAME);
    localparam int LW = $clog2(MAX_FRAME + 1);

    logic [PW-1:0] pos_reg;
    logic [PW-1:0] pos_next;
    logic [7:0]    total_reg;
    logic [7:0]    total_next;
    logic          bank_reg;
    logic          bank_next;

    logic          accept;
    logic [PW-1:0] p;
    logic [7:0]    p8;
    logic [7:0]    want;
    logic          len_ok;

    assign in_stall  = q_full;
    assign accept    = in_valid && !q_full;
    assign p         = pos_reg + PW'(1);
    assign p8        = 8'(p);
    assign len_ok    = (total_reg >= HDR_LEN) && (total_reg <= 8'(MAX_FRAME));
    assign wr_addr   = {bank_reg, AW'(p - PW'(1))};
    assign wr_data   = rx_byte;
    assign push_bank = bank_reg;
    assign push_len  = LW'(total_reg);

    always_comb
    begin
        unique case (p8)
            POS_SYNC0: want = SYNC_A;
            POS_SYNC1: want = SYNC_B;
            POS_SYNC2: want = SYNC_A;
            POS_SYNC3: want = SYNC_B;
            POS_TYPE:  want = FRAME_TYPE;
            default:   want = station_id;
        endcase
    end

    always_comb
    begin
        pos_next   = pos_reg;
        total_next = total_reg;
        bank_next  = bank_reg;
        wr_en      = 1'b0;
        push       = 1'b0;
        if (accept)
        begin
            pos_next = p;
            if (p8 <= POS_ADDR)
            begin
                if (rx_byte == want)
                begin
                    wr_en = 1'b1;
                end
                else
                begin
                    pos_next = '0;
                end
            end
            else if (p8 == POS_FREE)
            begin
                wr_en = 1'b1;
            end
            else if (p8 == POS_LEN)
            begin
                total_next = rx_byte + HDR_LEN;
                wr_en      = 1'b1;
            end
            else if (len_ok && (p8 == total_reg - 8'd3 || p8 == total_reg - 8'd1))
            begin
                if (rx_byte == TAIL_A)
                begin
                    wr_en = 1'b1;
                end
                else
                begin
                    pos_next = '0;
                end
            end
            else if (len_ok && p8 == total_reg - 8'd2)
            begin
                if (rx_byte == TAIL_B)
                begin
                    wr_en = 1'b1;
                end
                else
                begin
                    pos_next = '0;
                end
            end
            else if (len_ok && p8 == total_reg)
            begin
                pos_next = '0;
                if (rx_byte == TAIL_B)
                begin
                    wr_en     = 1'b1;
                    push      = 1'b1;
                    bank_next = ~bank_reg;
                end
            end
            else if (p > PW'(MAX_FRAME))
            begin
                pos_next = '0;
            end
            else if (len_ok)
            begin
                wr_en = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            total_reg <= '0;
            bank_reg  <= 1'b0;
        end
        else
        begin
            pos_reg   <= pos_next;
            total_reg <= total_next;
            bank_reg  <= bank_next;
        end
    end

endmodule

/* rtl/asfr_drain.sv */
// ----------------------------------------------------------------------------
// Frame drain
// Holds the two frame buffers and reads the queued frame out, one item per
// byte, marking the final byte.
// ----------------------------------------------------------------------------
module asfr_drain #(
    parameter int MAX_FRAME = 50
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 wr_en,
    input  logic [$clog2(MAX_FRAME):0]           wr_addr,
    input  logic [7:0]                           wr_data,
    input  logic                                 q_not_empty,
    input  logic                                 q_bank,
    input  logic [$clog2(MAX_FRAME + 1) - 1:0]   q_len,
    output logic                                 pop,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [7:0]                           frame_byte,
    output logic                                 frame_last
);

    localparam int AW    = $clog2(MAX_FRAME);
    localparam int LW    = $clog2(MAX_FRAME + 1);
    localparam int DEPTH = 2 ** (AW + 1);

    logic [7:0]    frame_mem [DEPTH];

    logic [AW-1:0] idx_reg;
    logic [AW-1:0] idx_next;
    logic          pend_reg;
    logic          pend_last_reg;
    logic [7:0]    rd_data_reg;
    logic          out_valid_reg;
    logic [7:0]    out_byte_reg;
    logic          out_last_reg;

    logic          rd_issue;
    logic          rd_last;

    assign rd_issue   = q_not_empty && !pend_reg && (!out_valid_reg || !out_stall);
    assign rd_last    = (LW'(idx_reg) == LW'(q_len - LW'(1)));
    assign pop        = rd_issue && rd_last;
    assign out_valid  = out_valid_reg;
    assign frame_byte = out_byte_reg;
    assign frame_last = out_last_reg;

    always_comb
    begin
        idx_next = idx_reg;
        if (rd_issue)
        begin
            idx_next = rd_last ? '0 : idx_reg + AW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            frame_mem[wr_addr] <= wr_data;
        end
        if (rd_issue)
        begin
            rd_data_reg <= frame_mem[{q_bank, idx_reg}];
        end
        if (pend_reg)
        begin
            out_byte_reg <= rd_data_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            pend_last_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            idx_reg  <= idx_next;
            pend_reg <= rd_issue;
            if (rd_issue)
            begin
                pend_last_reg <= rd_last;
            end
            if (pend_reg)
            begin
                out_valid_reg <= 1'b1;
                out_last_reg  <= pend_last_reg;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

/* rtl/addressed_serial_frame_receiver_top.sv */
// ----------------------------------------------------------------------------
// Addressed serial frame receiver
// Assembles addressed frames from received bytes and replays each complete
// frame as a run of bytes with the last one marked.
// ----------------------------------------------------------------------------
// A received byte is taken whenever a frame buffer is free. There are two
// buffers: one frame collects while the previous one drains, and the input
// stalls only when both hold completed frames. A completed frame leaves byte
// by byte through the single registered read port of the frame memory feeding
// the output register; each byte reaches the output register before the next
// read is issued, and out_stall holds the flow. No clearing pass follows reset.
`include "addressed_serial_frame_receiver_top_defines.svh"

module addressed_serial_frame_receiver_top #(
    parameter int MAX_FRAME = 50
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] frame_byte,
    output logic       frame_last
);

    localparam int AW = $clog2(MAX_FRAME);
    localparam int LW = $clog2(MAX_FRAME + 1);

    logic [7:0]    station_id_reg;

    logic          wr_en;
    logic [AW:0]   wr_addr;
    logic [7:0]    wr_data;
    logic          q_push;
    logic          q_push_bank;
    logic [LW-1:0] q_push_len;
    logic          q_pop;
    logic          q_full;
    logic          q_not_empty;
    logic          q_bank;
    logic [LW-1:0] q_len;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            station_id_reg <= 8'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            station_id_reg <= cfg_data;
        end
    end

    asfr_parser #(
        .MAX_FRAME (MAX_FRAME)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .rx_byte    (rx_byte),
        .station_id (station_id_reg),
        .q_full     (q_full),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .push       (q_push),
        .push_bank  (q_push_bank),
        .push_len   (q_push_len)
    );

    asfr_cmd_fifo #(
        .MAX_FRAME (MAX_FRAME)
    ) u_cmd_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_bank (q_push_bank),
        .push_len  (q_push_len),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head_bank (q_bank),
        .head_len  (q_len)
    );

    asfr_drain #(
        .MAX_FRAME (MAX_FRAME)
    ) u_drain (
        .clk         (clk),
        .rst_n       (rst_n),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .q_not_empty (q_not_empty),
        .q_bank      (q_bank),
        .q_len       (q_len),
        .pop         (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .frame_byte  (frame_byte),
        .frame_last  (frame_last)
    );

    `ASSERT_IMPL(a_push_has_room, clk, rst_n, q_push, !q_full)
    `ASSERT_IMPL(a_pop_not_empty, clk, rst_n, q_pop, q_not_empty)
    `ASSERT_NEXT(a_push_queued, clk, rst_n, q_push, q_not_empty)
    `ASSERT_IMPL(a_no_overwrite, clk, rst_n, wr_en && q_not_empty, wr_addr[AW] != q_bank)

endmodule
